// ===== src/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the color blob centroid block
// Field widths of the pixel, result and configuration channels, the frame
// queue depth, and the status bundle that the queue reports to the front and back ends.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // pixel and coordinate widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int COORD_MAX = 1023;

  // blue ratio register
  localparam int         RATIO_W     = 4;
  localparam logic [3:0] RATIO_RESET = 4'd5;

  // ratio * component product
  localparam int PROD_W = RATIO_W + PIX_W;

  // frame totals queued between front and back
  localparam int QUEUE_DEPTH = 2;

  // queue occupancy as seen by the producer and the consumer
  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } qstat_t;

endpackage

// ===== src/cbc_ifs.sv =====
// ----------------------------------------------------------------------------
// cbc_ifs: valid/ready channels of the color blob centroid block
// Pixel input channel, centroid result channel and the ratio write channel.
// ----------------------------------------------------------------------------
interface cbc_pix_if;
  logic                        valid;
  logic                        ready;
  logic [cbc_pkg::PIX_W-1:0]   red;
  logic [cbc_pkg::PIX_W-1:0]   green;
  logic [cbc_pkg::PIX_W-1:0]   blue;
  logic [cbc_pkg::COORD_W-1:0] column;
  logic [cbc_pkg::COORD_W-1:0] row;
  logic                        frame_end;

  modport source (output valid, red, green, blue, column, row, frame_end, input ready);
  modport sink   (input valid, red, green, blue, column, row, frame_end, output ready);
endinterface

interface cbc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [cbc_pkg::COORD_W-1:0] centroid_x;
  logic [cbc_pkg::COORD_W-1:0] centroid_y;

  modport source (output valid, found, centroid_x, centroid_y, input ready);
  modport sink   (input valid, found, centroid_x, centroid_y, output ready);
endinterface

interface cbc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbc_pkg::RATIO_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/cbc_queue.sv =====
// ----------------------------------------------------------------------------
// cbc_queue: short FIFO of frame totals
// Holds finished frame sums and counts until the divider takes them, so
// that pixel accumulation and division stall independently.
// ----------------------------------------------------------------------------
module cbc_queue #(
  parameter int WIDTH = 81
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output cbc_pkg::qstat_t       qstat
);

  localparam int DEPTH = cbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // status
  assign qstat.empty    = (cnt_r == '0);
  assign qstat.full     = (cnt_r == CNT_W'(DEPTH));
  assign qstat.one_left = (cnt_r == CNT_W'(DEPTH - 1));
  assign pop_data       = mem_r[rd_ptr_r];

  // pointer and count update, wrapping at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // the front end must never overrun, the back end never underrun
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("frame queue pushed while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("frame queue popped while empty");

endmodule

// ===== src/cbc_front.sv =====
// ----------------------------------------------------------------------------
// cbc_front: pixel classifier and frame accumulator
// Stage one tests blue against ratio times red and green; stage two adds the
// coordinates of matching pixels and queues the frame totals at frame end.
// ----------------------------------------------------------------------------
module cbc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  cbc_pix_if.sink                pix,
  cbc_cfg_if.sink                cfg,
  input  cbc_pkg::qstat_t        qstat,
  output logic                   push,
  output logic [$clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1) * 3
                + 2 * cbc_pkg::COORD_W - 1 - 2 * $clog2(longint'(MAX_WIDTH)
                * longint'(MAX_HEIGHT) + 1) + 2 * $clog2(longint'(MAX_WIDTH)
                * longint'(MAX_HEIGHT) * cbc_pkg::COORD_MAX + 1)
                - 2 * cbc_pkg::COORD_W:0] push_data
);

  localparam longint CAP   = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int     CNT_W = $clog2(CAP + 1);
  localparam int     SUM_W = $clog2(CAP * cbc_pkg::COORD_MAX + 1);
  localparam int     CW    = cbc_pkg::COORD_W;

  logic [cbc_pkg::RATIO_W-1:0] ratio_r;
  logic [cbc_pkg::PROD_W-1:0]  prod_red, prod_green;
  logic                        match;
  logic                        accept;

  logic          s1_valid_r;
  logic          s1_match_r;
  logic          s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [CW-1:0] s1_row_r;

  logic [SUM_W-1:0] col_sum_r, col_sum_nxt, col_sum_add;
  logic [SUM_W-1:0] row_sum_r, row_sum_nxt, row_sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_add;
  logic             take;

  // ratio register, writes accepted at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= cbc_pkg::RATIO_RESET;
    end else if (cfg.valid) begin
      ratio_r <= cfg.data;
    end
  end

  // hold off input when a pending frame end could not find room in the queue
  assign pix.ready = !qstat.full && !(qstat.one_left && s1_valid_r && s1_last_r);
  assign accept    = pix.valid && pix.ready;

  // classify
  assign prod_red   = cbc_pkg::PROD_W'(ratio_r) * cbc_pkg::PROD_W'(pix.red);
  assign prod_green = cbc_pkg::PROD_W'(ratio_r) * cbc_pkg::PROD_W'(pix.green);
  assign match      = (cbc_pkg::PROD_W'(pix.blue) > prod_red) &&
                      (cbc_pkg::PROD_W'(pix.blue) > prod_green);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_match_r <= match;
      s1_last_r  <= pix.frame_end;
      s1_col_r   <= pix.column;
      s1_row_r   <= pix.row;
    end
  end

  // accumulate; matches past the cap are dropped until frame end
  assign take        = s1_valid_r && s1_match_r && (cnt_r < CNT_W'(CAP));
  assign col_sum_add = take ? col_sum_r + SUM_W'(s1_col_r) : col_sum_r;
  assign row_sum_add = take ? row_sum_r + SUM_W'(s1_row_r) : row_sum_r;
  assign cnt_add     = take ? cnt_r + 1'b1 : cnt_r;

  assign push      = s1_valid_r && s1_last_r;
  assign push_data = {cnt_add, row_sum_add, col_sum_add};

  always_comb begin
    col_sum_nxt = col_sum_add;
    row_sum_nxt = row_sum_add;
    cnt_nxt     = cnt_add;
    if (push) begin
      col_sum_nxt = '0;
      row_sum_nxt = '0;
      cnt_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_sum_r <= '0;
      row_sum_r <= '0;
      cnt_r     <= '0;
    end else begin
      col_sum_r <= col_sum_nxt;
      row_sum_r <= row_sum_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // count never passes the cap, sums stay zero while nothing matched
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("match count above cap");

  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> col_sum_r == '0 && row_sum_r == '0)
    else $error("sums nonzero with no matches");

endmodule

// ===== src/cbc_back.sv =====
// ----------------------------------------------------------------------------
// cbc_back: centroid divider and result register
// Takes one frame's totals from the queue, divides both sums by the count
// with a shared restoring divider, one quotient bit per cycle, and holds the
// result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module cbc_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbc_pkg::qstat_t        qstat,
  input  logic [$clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1)
                + 2 * $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT)
                * cbc_pkg::COORD_MAX + 1) - 1:0] pop_data,
  output logic                   pop,
  cbc_res_if.source              res
);

  localparam longint CAP    = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int     CNT_W  = $clog2(CAP + 1);
  localparam int     SUM_W  = $clog2(CAP * cbc_pkg::COORD_MAX + 1);
  localparam int     CW     = cbc_pkg::COORD_W;
  localparam int     DIV_W  = CNT_W + CW;
  localparam int     STEP_W = $clog2(CW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0]  q_col_sum, q_row_sum;
  logic [CNT_W-1:0]  q_cnt;

  logic [DIV_W-1:0]  rem_x_r, rem_x_nxt;
  logic [DIV_W-1:0]  rem_y_r, rem_y_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [CW-1:0]     quo_x_r, quo_x_nxt;
  logic [CW-1:0]     quo_y_r, quo_y_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              hit_r, hit_nxt;
  logic              ge_x, ge_y;

  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     cx_r, cx_nxt;
  logic [CW-1:0]     cy_r, cy_nxt;

  assign {q_cnt, q_row_sum, q_col_sum} = pop_data;

  assign ge_x = (rem_x_r >= div_r);
  assign ge_y = (rem_y_r >= div_r);

  // sequencer: load, ten divide steps, hand off to the output register
  always_comb begin
    state_nxt     = state_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    div_nxt       = div_r;
    quo_x_nxt     = quo_x_r;
    quo_y_nxt     = quo_y_r;
    step_nxt      = step_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    pop           = 1'b0;

    if (out_valid_r && res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          rem_x_nxt = DIV_W'(q_col_sum);
          rem_y_nxt = DIV_W'(q_row_sum);
          div_nxt   = {q_cnt, {(CW - 1){1'b0}}, 1'b0} >> 1;
          hit_nxt   = (q_cnt != '0);
          step_nxt  = STEP_W'(CW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_x_nxt = ge_x ? rem_x_r - div_r : rem_x_r;
        rem_y_nxt = ge_y ? rem_y_r - div_r : rem_y_r;
        quo_x_nxt = {quo_x_r[CW-2:0], ge_x};
        quo_y_nxt = {quo_y_r[CW-2:0], ge_y};
        div_nxt   = div_r >> 1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || res.ready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = hit_r;
          cx_nxt        = hit_r ? quo_x_r : '0;
          cy_nxt        = hit_r ? quo_y_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result payload, no reset
  always_ff @(posedge clk) begin
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    div_r   <= div_nxt;
    quo_x_r <= quo_x_nxt;
    quo_y_r <= quo_y_nxt;
    step_r  <= step_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
  end

  assign res.valid      = out_valid_r;
  assign res.found      = found_r;
  assign res.centroid_x = cx_r;
  assign res.centroid_y = cy_r;

  // an empty frame reports the origin
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !res.found |-> res.centroid_x == '0 && res.centroid_y == '0)
    else $error("no-match result carries nonzero centroid");

endmodule

// ===== src/color_blob_centroid_top.sv =====
// ----------------------------------------------------------------------------
// color_blob_centroid_top: color threshold blob centroid
// Finds the mean column and row of the pixels in a frame whose blue exceeds
// a programmable multiple of both red and green.
//
// Usage:
//   in_pix  - one pixel item per accepted cycle (valid/ready): RGB, column,
//             row and frame_end on the last pixel of the frame. Pixels stream
//             at one per cycle unless the queue is full, or has one free entry
//             while a finished frame is still on its way into it.
//   out_res - one result item per frame: found, centroid_x, centroid_y.
//   cfg_wr  - blue_ratio write, always ready; write only while idle.
//   Path: the frame_end pixel passes two front stages and the queue pop, then
//   the divider produces one quotient bit of both coordinates per cycle and
//   hands the result to the output register. The divider takes a new frame
//   only after handing the previous result to the output register.
//   Reset: sums and counts clear, blue_ratio returns to 5, queue empties.
//   Receiver stall: the result stays in the output register; the divider and
//   queue hold further frames, and the pixel input keeps running until the
//   queue has no room for another frame.
// ----------------------------------------------------------------------------
module color_blob_centroid_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  cbc_pix_if.sink   in_pix,
  cbc_res_if.source out_res,
  cbc_cfg_if.sink   cfg_wr
);

  localparam longint CAP   = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int     CNT_W = $clog2(CAP + 1);
  localparam int     SUM_W = $clog2(CAP * cbc_pkg::COORD_MAX + 1);
  localparam int     ENT_W = CNT_W + 2 * SUM_W;

  cbc_pkg::qstat_t  qstat;
  logic             push, pop;
  logic [ENT_W-1:0] push_data, pop_data;

  // pixel classification and accumulation
  cbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .cfg       (cfg_wr),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // frame totals queue
  cbc_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // divider and result register
  cbc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .pop_data (pop_data),
    .pop      (pop),
    .res      (out_res)
  );

endmodule
